// ----- hw/rtl/stok_pkg.sv -----
package stok_pkg;

    localparam int PosBitsDefault = 24;
    localparam int FieldBits      = 24;
    localparam int KindBits       = 6;

    localparam logic [KindBits-1:0] K_LPAREN     = 6'd0;
    localparam logic [KindBits-1:0] K_RPAREN     = 6'd1;
    localparam logic [KindBits-1:0] K_LBRACE     = 6'd2;
    localparam logic [KindBits-1:0] K_RBRACE     = 6'd3;
    localparam logic [KindBits-1:0] K_DOT        = 6'd4;
    localparam logic [KindBits-1:0] K_COMMA      = 6'd5;
    localparam logic [KindBits-1:0] K_MINUS      = 6'd6;
    localparam logic [KindBits-1:0] K_PLUS       = 6'd7;
    localparam logic [KindBits-1:0] K_SEMI       = 6'd8;
    localparam logic [KindBits-1:0] K_COLON      = 6'd9;
    localparam logic [KindBits-1:0] K_QUEST      = 6'd10;
    localparam logic [KindBits-1:0] K_SLASH      = 6'd11;
    localparam logic [KindBits-1:0] K_STAR       = 6'd12;
    localparam logic [KindBits-1:0] K_BANG       = 6'd13;
    localparam logic [KindBits-1:0] K_IDENT      = 6'd21;
    localparam logic [KindBits-1:0] K_STRING     = 6'd22;
    localparam logic [KindBits-1:0] K_NUMBER     = 6'd23;
    localparam logic [KindBits-1:0] K_KEYWORD0   = 6'd24;
    localparam logic [KindBits-1:0] K_EOF        = 6'd42;
    localparam logic [KindBits-1:0] K_ERR_CHAR   = 6'd43;
    localparam logic [KindBits-1:0] K_ERR_STRING = 6'd44;

    // Token as it leaves the front end, with fields already clamped to field width.
    typedef struct packed {
        logic [KindBits-1:0]  kind;
        logic [FieldBits-1:0] start;
        logic [FieldBits-1:0] len;
        logic [FieldBits-1:0] line;
        logic                 last;
    } t_token;

    // w holds the first byte in bits 7:0; rv puts it in the top byte
    function automatic logic [KindBits-1:0] kw_kind(input logic [55:0] w,
                                                    input logic [2:0] n);
        logic [KindBits-1:0] k;
        logic [55:0]         rv;
        for (int i = 0; i < 7; i++) begin
            rv[8*(6-i) +: 8] = w[8*i +: 8];
        end
        k = K_IDENT;
        case (n)
            3'd2: begin
                if (rv[55:40] == "fn") k = K_KEYWORD0 + 6'd5;
                if (rv[55:40] == "if") k = K_KEYWORD0 + 6'd7;
                if (rv[55:40] == "or") k = K_KEYWORD0 + 6'd10;
            end
            3'd3: begin
                if (rv[55:32] == "and") k = K_KEYWORD0 + 6'd0;
                if (rv[55:32] == "for") k = K_KEYWORD0 + 6'd6;
                if (rv[55:32] == "nil") k = K_KEYWORD0 + 6'd9;
                if (rv[55:32] == "var") k = K_KEYWORD0 + 6'd16;
            end
            3'd4: begin
                if (rv[55:24] == "else") k = K_KEYWORD0 + 6'd2;
                if (rv[55:24] == "impl") k = K_KEYWORD0 + 6'd8;
                if (rv[55:24] == "self") k = K_KEYWORD0 + 6'd14;
                if (rv[55:24] == "true") k = K_KEYWORD0 + 6'd15;
            end
            3'd5: begin
                if (rv[55:16] == "class") k = K_KEYWORD0 + 6'd1;
                if (rv[55:16] == "false") k = K_KEYWORD0 + 6'd3;
                if (rv[55:16] == "fixed") k = K_KEYWORD0 + 6'd4;
                if (rv[55:16] == "print") k = K_KEYWORD0 + 6'd11;
                if (rv[55:16] == "super") k = K_KEYWORD0 + 6'd13;
                if (rv[55:16] == "while") k = K_KEYWORD0 + 6'd17;
            end
            3'd6: begin
                if (rv[55:8] == "return") k = K_KEYWORD0 + 6'd12;
            end
            default: k = K_IDENT;
        endcase
        return k;
    endfunction

endpackage

// ----- hw/rtl/stok_front.sv -----
module stok_front #(
    parameter int POSITION_BITS = stok_pkg::PosBitsDefault
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_mode,
    input  logic [7:0]      i_char_byte,
    output logic [1:0]      o_count,
    output stok_pkg::t_token o_tok0,
    output stok_pkg::t_token o_tok1,
    output stok_pkg::t_token o_tok2
);
    import stok_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE, PH_COMMENT, PH_SLASH, PH_OP, PH_STRING,
        PH_NUMBER, PH_NUMDOT, PH_FRACTION, PH_WORD
    } t_phase;

    localparam logic [POSITION_BITS-1:0] PosMax = '1;
    localparam logic [FieldBits-1:0]     LineMax = '1;

    t_phase                   r_phase, n_phase;
    logic [1:0]               r_op, n_op;
    logic [POSITION_BITS-1:0] r_start, n_start;
    logic [POSITION_BITS-1:0] r_pos, n_pos;
    logic [FieldBits-1:0]     r_line, n_line;
    logic [55:0]              r_word, n_word;
    logic [2:0]               r_wlen, n_wlen;

    logic [7:0] c;
    logic ending, fresh, is_dig, is_alp;
    logic [POSITION_BITS-1:0] run, run_inc, run_dec, pos_dec;
    logic [KindBits-1:0] opk;
    logic [1:0] n;
    t_token t [3];

    function automatic logic [FieldBits-1:0] clampf(input logic [POSITION_BITS-1:0] v);
        logic [POSITION_BITS:0] w;
        w = {1'b0, v};
        if (w > (POSITION_BITS+1)'(LineMax)) return LineMax;
        return FieldBits'(w);
    endfunction

    always_comb begin
        c       = i_char_byte;
        ending  = i_mode || (c == 8'd0);
        is_dig  = (c >= "0") && (c <= "9");
        is_alp  = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
        run     = (r_pos > r_start) ? r_pos - r_start : '0;
        run_inc = (run != PosMax) ? run + 1'b1 : PosMax;
        run_dec = (run != '0) ? run - 1'b1 : '0;
        pos_dec = (r_pos != '0) ? r_pos - 1'b1 : '0;
        opk     = K_BANG + {3'd0, r_op, 1'b0};
        n_phase = r_phase;
        n_op    = r_op;
        n_start = r_start;
        n_pos   = r_pos;
        n_line  = r_line;
        n_word  = r_word;
        n_wlen  = r_wlen;
        fresh   = 1'b0;
        n       = 2'd0;
        for (int k = 0; k < 3; k++) begin
            t[k] = '0;
        end

        case (r_phase)
            PH_COMMENT: begin
                if (!ending && c == 8'h0A) begin
                    n_phase = PH_IDLE; fresh = 1'b1;
                end
            end
            PH_SLASH: begin
                if (!ending && c == "/") n_phase = PH_COMMENT;
                else begin
                    t[0] = '{K_SLASH, clampf(r_start), clampf(run), r_line, 1'b0};
                    n = 2'd1; n_phase = PH_IDLE; fresh = 1'b1;
                end
            end
            PH_OP: begin
                if (!ending && c == "=") begin
                    t[0] = '{opk + 6'd1, clampf(r_start), clampf(run_inc), r_line, 1'b0};
                    n = 2'd1; n_phase = PH_IDLE;
                end else begin
                    t[0] = '{opk, clampf(r_start), clampf(run), r_line, 1'b0};
                    n = 2'd1; n_phase = PH_IDLE; fresh = 1'b1;
                end
            end
            PH_STRING: begin
                if (ending) begin
                    t[0] = '{K_ERR_STRING, clampf(r_start), clampf(run), r_line, 1'b0};
                    n = 2'd1; n_phase = PH_IDLE;
                end else if (c == "\"") begin
                    t[0] = '{K_STRING, clampf(r_start), clampf(run_inc), r_line, 1'b0};
                    n = 2'd1; n_phase = PH_IDLE;
                end else if (c == 8'h0A) begin
                    if (r_line != LineMax) n_line = r_line + 1'b1;
                end
            end
            PH_NUMBER, PH_FRACTION: begin
                if (!ending && is_dig) begin
                end else if (!ending && c == "." && r_phase == PH_NUMBER) begin
                    n_phase = PH_NUMDOT;
                end else begin
                    t[0] = '{K_NUMBER, clampf(r_start), clampf(run), r_line, 1'b0};
                    n = 2'd1; n_phase = PH_IDLE; fresh = 1'b1;
                end
            end
            PH_NUMDOT: begin
                if (!ending && is_dig) n_phase = PH_FRACTION;
                else begin
                    t[0] = '{K_NUMBER, clampf(r_start), clampf(run_dec), r_line, 1'b0};
                    t[1] = '{K_DOT, clampf(pos_dec), FieldBits'(1), r_line, 1'b0};
                    n = 2'd2; n_phase = PH_IDLE; fresh = 1'b1;
                end
            end
            PH_WORD: begin
                if (!ending && (is_alp || is_dig || c == "_")) begin
                    if (r_wlen != 3'd7) begin
                        n_word[8*r_wlen +: 8] = c;
                        n_wlen = r_wlen + 3'd1;
                    end
                end else begin
                    t[0] = '{kw_kind(r_word, r_wlen), clampf(r_start), clampf(run),
                             r_line, 1'b0};
                    n = 2'd1; n_phase = PH_IDLE; fresh = 1'b1;
                end
            end
            default: begin
                n_phase = PH_IDLE; fresh = 1'b1;
            end
        endcase

        if (ending) begin
            t[n] = '{K_EOF, clampf(r_pos), '0, n_line, 1'b1};
            n = n + 2'd1;
            n_phase = PH_IDLE; n_op = '0; n_start = '0; n_pos = '0;
            n_line = FieldBits'(1); n_wlen = '0;
        end else begin
            if (fresh) begin
                n_start = r_pos;
                if (c == 8'h0A) begin
                    if (n_line != LineMax) n_line = n_line + 1'b1;
                end else if (c == " " || c == 8'h0D || c == 8'h09) begin
                end else if (c == "/") n_phase = PH_SLASH;
                else if (c == "\"") n_phase = PH_STRING;
                else if (is_dig) n_phase = PH_NUMBER;
                else if (is_alp || c == "_") begin
                    n_phase = PH_WORD;
                    n_word[7:0] = c;
                    n_wlen = 3'd1;
                end else if (c == "!" || c == "=" || c == ">" || c == "<") begin
                    n_phase = PH_OP;
                    n_op = (c == "!") ? 2'd0 : (c == "=") ? 2'd1 : (c == ">") ? 2'd2 : 2'd3;
                end else begin
                    t[n] = '{K_ERR_CHAR, clampf(r_pos), FieldBits'(1), n_line, 1'b0};
                    case (c)
                        "(": t[n].kind = K_LPAREN;
                        ")": t[n].kind = K_RPAREN;
                        "{": t[n].kind = K_LBRACE;
                        "}": t[n].kind = K_RBRACE;
                        ".": t[n].kind = K_DOT;
                        ",": t[n].kind = K_COMMA;
                        "-": t[n].kind = K_MINUS;
                        "+": t[n].kind = K_PLUS;
                        ";": t[n].kind = K_SEMI;
                        ":": t[n].kind = K_COLON;
                        "?": t[n].kind = K_QUEST;
                        "*": t[n].kind = K_STAR;
                        default: t[n].kind = K_ERR_CHAR;
                    endcase
                    n = n + 2'd1;
                end
            end
            if (r_pos != PosMax) n_pos = r_pos + 1'b1;
            if (n != 2'd0) t[n-2'd1].last = 1'b1;
        end
        // tokens from the string path carry the line seen before this beat
        o_count = n;
        o_tok0  = t[0];
        o_tok1  = t[1];
        o_tok2  = t[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_op    <= '0;
            r_start <= '0;
            r_pos   <= '0;
            r_line  <= FieldBits'(1);
            r_wlen  <= '0;
        end else if (i_valid) begin
            r_phase <= n_phase;
            r_op    <= n_op;
            r_start <= n_start;
            r_pos   <= n_pos;
            r_line  <= n_line;
            r_wlen  <= n_wlen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) r_word <= n_word;
    end

endmodule

// ----- hw/rtl/stok_queue.sv -----
module stok_queue #(
    parameter int DEPTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [1:0]       i_count,
    input  stok_pkg::t_token i_tok0,
    input  stok_pkg::t_token i_tok1,
    input  stok_pkg::t_token i_tok2,
    output logic             o_room,
    output logic             o_empty,
    output stok_pkg::t_token o_head,
    input  logic             i_pop
);
    import stok_pkg::*;

    localparam int AW = $clog2(DEPTH);

    t_token          r_mem [DEPTH];
    logic [AW-1:0]   r_wr, r_rd;
    logic [AW:0]     r_cnt;
    logic            pop_ok;
    logic [AW-1:0]   wa1, wa2;

    always_comb begin
        pop_ok  = i_pop && (r_cnt != '0);
        o_empty = (r_cnt == '0);
        o_head  = r_mem[r_rd];
        o_room  = (r_cnt <= (AW+1)'(DEPTH - 3));
        wa1     = r_wr + AW'(1);
        wa2     = r_wr + AW'(2);
    end

    always_ff @(posedge i_clk) begin
        if (i_count != 2'd0) r_mem[r_wr] <= i_tok0;
        if (i_count >= 2'd2) r_mem[wa1]  <= i_tok1;
        if (i_count == 2'd3) r_mem[wa2]  <= i_tok2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + AW'(i_count);
            if (pop_ok) r_rd <= r_rd + AW'(1);
            r_cnt <= r_cnt + (AW+1)'(i_count) - (AW+1)'(pop_ok);
        end
    end

endmodule

// ----- hw/rtl/source_tokenizer.sv -----
// A token enters the queue at the clock edge that accepts the byte completing it.
// Throughput: one byte per cycle while not full; full rises while fewer than 3
// queue slots are free, so up to 3 tokens per byte drain one per cycle on pop.
// Reset (synchronous, i_rst_n low): scanner idle, offset 0, line 1, queue empty.
module source_tokenizer #(
    parameter int POSITION_BITS = stok_pkg::PosBitsDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_mode,
    input  logic [7:0]  i_char_byte,
    output logic        empty,
    input  logic        pop,
    output logic [5:0]  o_kind,
    output logic [23:0] o_start_offset,
    output logic [23:0] o_token_length,
    output logic [23:0] o_line_number,
    output logic        o_last
);
    import stok_pkg::*;

    logic       acc, room;
    logic [1:0] cnt;
    t_token     tok0, tok1, tok2, head;

    assign full = !room;
    assign acc  = push && room;

    stok_front #(.POSITION_BITS(POSITION_BITS)) u_front (
        .i_clk, .i_rst_n, .i_valid(acc), .i_mode, .i_char_byte,
        .o_count(cnt), .o_tok0(tok0), .o_tok1(tok1), .o_tok2(tok2)
    );

    stok_queue #(.DEPTH(8)) u_queue (
        .i_clk, .i_rst_n, .i_count(acc ? cnt : 2'd0),
        .i_tok0(tok0), .i_tok1(tok1), .i_tok2(tok2),
        .o_room(room), .o_empty(empty), .o_head(head), .i_pop(pop)
    );

    assign o_kind         = head.kind;
    assign o_start_offset = head.start;
    assign o_token_length = head.len;
    assign o_line_number  = head.line;
    assign o_last         = head.last;

endmodule

// ----- test/source_tokenizer_test.sv -----
`timescale 1ns / 100ps

module source_tokenizer_test;
    import stok_pkg::*;

    localparam int CycleLimit = 400000;
    localparam int PosMax = 24'hFFFFFF;

    localparam int PhIdle = 0;
    localparam int PhComment = 1;
    localparam int PhSlash = 2;
    localparam int PhOp = 3;
    localparam int PhString = 4;
    localparam int PhNumber = 5;
    localparam int PhNumDot = 6;
    localparam int PhFraction = 7;
    localparam int PhWord = 8;

    typedef struct packed {
        logic [5:0]  kind;
        logic [23:0] start;
        logic [23:0] len;
        logic [23:0] line;
        logic        last;
    } t_tok;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic        i_mode;
    logic [7:0]  i_char_byte;
    logic        empty;
    logic        pop;
    logic [5:0]  o_kind;
    logic [23:0] o_start_offset;
    logic [23:0] o_token_length;
    logic [23:0] o_line_number;
    logic        o_last;

    source_tokenizer u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .push(push),
        .full(full),
        .i_mode(i_mode),
        .i_char_byte(i_char_byte),
        .empty(empty),
        .pop(pop),
        .o_kind(o_kind),
        .o_start_offset(o_start_offset),
        .o_token_length(o_token_length),
        .o_line_number(o_line_number),
        .o_last(o_last)
    );

    t_tok expected_tokens[$];
    int   mismatch_count;
    int   cycle_count;
    bit   pop_idle;

    // scanner state copy
    int        phase;
    int        pend_op;
    int        tok_start;
    int        byte_pos;
    int        line_cnt;
    bit [7:0]  word_buf[7];
    int        word_len;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    task automatic report(input string what, input logic [23:0] got, input logic [23:0] exp);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, exp, cycle_count);
        mismatch_count++;
    endtask

    function automatic int sat_inc(input int v);
        return v < PosMax ? v + 1 : PosMax;
    endfunction

    function automatic bit is_digit(input bit [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_alpha(input bit [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit word_is(input string s);
        if (s.len() != word_len) return 0;
        for (int i = 0; i < s.len(); i++)
            if (word_buf[i] != s[i]) return 0;
        return 1;
    endfunction

    function automatic logic [5:0] word_token();
        string kws[18];
        kws = '{"and", "class", "else", "false", "fixed", "fn", "for", "if", "impl",
                "nil", "or", "print", "return", "super", "self", "true", "var", "while"};
        for (int i = 0; i < 18; i++)
            if (word_is(kws[i])) return K_KEYWORD0 + 6'(i);
        return K_IDENT;
    endfunction

    function automatic void add_token(input logic [5:0] k, input int s, input int l);
        t_tok t;
        t.kind = k;
        t.start = s[23:0];
        t.len = l[23:0];
        t.line = line_cnt[23:0];
        t.last = 1'b0;
        expected_tokens.push_back(t);
    endfunction

    function automatic void clear_scanner();
        phase = PhIdle;
        pend_op = 0;
        tok_start = 0;
        byte_pos = 0;
        line_cnt = 1;
        word_len = 0;
    endfunction

    function automatic void predict_tokens(input bit m, input bit [7:0] c);
        bit ending;
        bit fresh;
        int prior;
        int run;
        logic [5:0] op_k[4];
        logic [5:0] k;
        op_k = '{K_BANG, K_BANG + 6'd2, K_BANG + 6'd4, K_BANG + 6'd6};
        ending = m || c == 8'd0;
        fresh = 0;
        prior = expected_tokens.size();
        run = byte_pos > tok_start ? byte_pos - tok_start : 0;
        case (phase)
            PhComment: if (!ending && c == "\n") begin
                phase = PhIdle;
                fresh = 1;
            end
            PhSlash: begin
                if (!ending && c == "/") phase = PhComment;
                else begin
                    add_token(K_SLASH, tok_start, run);
                    phase = PhIdle;
                    fresh = 1;
                end
            end
            PhOp: begin
                if (!ending && c == "=") begin
                    add_token(op_k[pend_op] + 6'd1, tok_start, sat_inc(run));
                    phase = PhIdle;
                end else begin
                    add_token(op_k[pend_op], tok_start, run);
                    phase = PhIdle;
                    fresh = 1;
                end
            end
            PhString: begin
                if (ending) begin
                    add_token(K_ERR_STRING, tok_start, run);
                    phase = PhIdle;
                end else if (c == "\"") begin
                    add_token(K_STRING, tok_start, sat_inc(run));
                    phase = PhIdle;
                end else if (c == "\n") line_cnt = sat_inc(line_cnt);
            end
            PhNumber, PhFraction: begin
                if (!ending && is_digit(c)) begin
                end else if (!ending && c == "." && phase == PhNumber) phase = PhNumDot;
                else begin
                    add_token(K_NUMBER, tok_start, run);
                    phase = PhIdle;
                    fresh = 1;
                end
            end
            PhNumDot: begin
                if (!ending && is_digit(c)) phase = PhFraction;
                else begin
                    add_token(K_NUMBER, tok_start, run > 0 ? run - 1 : 0);
                    add_token(K_DOT, byte_pos > 0 ? byte_pos - 1 : 0, 1);
                    phase = PhIdle;
                    fresh = 1;
                end
            end
            PhWord: begin
                if (!ending && (is_alpha(c) || is_digit(c) || c == "_")) begin
                    if (word_len < 7) begin
                        word_buf[word_len] = c;
                        word_len++;
                    end
                end else begin
                    add_token(word_token(), tok_start, run);
                    phase = PhIdle;
                    fresh = 1;
                end
            end
            default: begin
                phase = PhIdle;
                fresh = 1;
            end
        endcase
        if (ending) begin
            add_token(K_EOF, byte_pos, 0);
            expected_tokens[expected_tokens.size() - 1].last = 1'b1;
            clear_scanner();
            return;
        end
        if (fresh) begin
            tok_start = byte_pos;
            if (c == "\n") line_cnt = sat_inc(line_cnt);
            else if (c == " " || c == "\r" || c == "\t") begin
            end else if (c == "/") phase = PhSlash;
            else if (c == "\"") phase = PhString;
            else if (is_digit(c)) phase = PhNumber;
            else if (is_alpha(c) || c == "_") begin
                phase = PhWord;
                word_buf[0] = c;
                word_len = 1;
            end else begin
                k = K_ERR_CHAR;
                case (c)
                    "!": begin pend_op = 0; phase = PhOp; end
                    "=": begin pend_op = 1; phase = PhOp; end
                    ">": begin pend_op = 2; phase = PhOp; end
                    "<": begin pend_op = 3; phase = PhOp; end
                    "(": k = K_LPAREN;
                    ")": k = K_RPAREN;
                    "{": k = K_LBRACE;
                    "}": k = K_RBRACE;
                    ".": k = K_DOT;
                    ",": k = K_COMMA;
                    "-": k = K_MINUS;
                    "+": k = K_PLUS;
                    ";": k = K_SEMI;
                    ":": k = K_COLON;
                    "?": k = K_QUEST;
                    "*": k = K_STAR;
                    default: ;
                endcase
                if (phase != PhOp) add_token(k, tok_start, 1);
            end
        end
        byte_pos = sat_inc(byte_pos);
        if (expected_tokens.size() > prior)
            expected_tokens[expected_tokens.size() - 1].last = 1'b1;
    endfunction

    task automatic send_beat(input bit m, input bit [7:0] c);
        int g;
        g = gap_length();
        if (g != 0) begin
            push <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        push <= 1'b1;
        i_mode <= m;
        i_char_byte <= c;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        predict_tokens(m, c);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_beat(1'b0, s[i]);
    endtask

    task automatic test_operators();
        send_text("(){}.,-+;:?*/ ! != = == > >= < <=");
        send_text("a/b//comment ( ignored\n!x");
        send_beat(1'b1, 8'hA5);
    endtask

    task automatic test_keywords();
        send_text("and class else false fixed fn for if impl nil or print return ");
        send_text("super self true var while impls _x9 returned abcdefghij\n");
        send_beat(1'b1, 8'h00);
    endtask

    task automatic test_literals();
        send_text("12.5 7. 3.x 42\"ab\ncd\" \t\r@");
        send_beat(1'b0, 8'hFF);
        send_beat(1'b0, 8'h01);
        send_text("\"open");
        send_beat(1'b0, 8'h00);
        send_text("9.");
        send_beat(1'b1, 8'h00);
        send_text("<");
        send_beat(1'b1, 8'h7F);
    endtask

    task automatic test_random_text();
        string pieces[24];
        string p;
        int r;
        pieces = '{"if", "fixed", "impl", "while", "foo_1", "x", "return", "var",
                   "123", "4.56", "7.", "\"str\"", "\"a\nb\"", "// note\n", "==",
                   "!=", "<=", ">=", "/", "(", ")", "\n", " ", ";"};
        for (int n = 0; n < 90; ) begin
            r = $urandom_range(0, 99);
            if (r < 75) begin
                p = pieces[$urandom_range(0, 23)];
                send_text(p);
                n += p.len();
                if ($urandom_range(0, 1)) begin
                    send_beat(1'b0, " ");
                    n++;
                end
            end else if (r < 95) begin
                send_beat(1'b0, 8'($urandom_range(1, 255)));
                n++;
            end else begin
                send_beat(1'($urandom_range(0, 1)),
                          $urandom_range(0, 1) ? 8'd0 : 8'($urandom));
                n++;
            end
        end
        send_beat(1'b1, 8'h00);
    endtask

    always @(posedge i_clk) begin
        t_tok exp;
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("simulation failed");
            $finish;
        end
        if (i_rst_n && pop && !empty) begin
            if (expected_tokens.size() == 0) begin
                report("unexpected token kind", 24'(o_kind), 24'd0);
            end else begin
                exp = expected_tokens.pop_front();
                if (o_kind != exp.kind) report("kind", 24'(o_kind), 24'(exp.kind));
                if (o_start_offset != exp.start) report("start", o_start_offset, exp.start);
                if (o_token_length != exp.len) report("length", o_token_length, exp.len);
                if (o_line_number != exp.line) report("line", o_line_number, exp.line);
                if (o_last != exp.last) report("last", 24'(o_last), 24'(exp.last));
            end
        end
        if (pop_idle) pop <= ($urandom_range(0, 99) < 70);
        else pop <= 1'b1;
    end

    always begin
        repeat ($urandom_range(20, 200)) @(posedge i_clk);
        pop_idle = ~pop_idle;
    end

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        i_mode = 1'b0;
        i_char_byte = 8'd0;
        mismatch_count = 0;
        cycle_count = 0;
        pop_idle = 1'b0;
        clear_scanner();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_operators();
        test_keywords();
        test_literals();
        test_random_text();
        push <= 1'b0;
        while (expected_tokens.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && empty) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/stok_pkg.sv
hw/rtl/stok_front.sv
hw/rtl/stok_queue.sv
hw/rtl/source_tokenizer.sv
test/source_tokenizer_test.sv
